// ===== hdl/sse_pkg.sv =====
package sse_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_FEED   = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_RESET  = 2'd2;

  // Result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  // Stream characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Event name storage
  localparam int EVENT_NAME_BYTES = 8;
  localparam int NAME_IDX_W = (EVENT_NAME_BYTES > 1) ? $clog2(EVENT_NAME_BYTES) : 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // One queue record: the results one item causes, payload byte first
  typedef struct packed {
    logic        has_payload;
    logic [7:0]  payload_byte;
    logic        has_summary;
    logic [31:0] data_length;
    logic [63:0] event_name;
    logic [3:0]  event_name_length;
    logic        name_truncated;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== hdl/sse_front.sv =====
module sse_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           operation,
  input  logic [7:0]           in_byte,
  input  sse_pkg::queue_status_t q_status,
  output logic                 q_push,
  output sse_pkg::queue_entry_t  q_entry
);

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_NAME   = 2'd1,
    PH_VSTART = 2'd2,
    PH_VREST  = 2'd3
  } line_phase_t;

  typedef enum logic [1:0] {
    LK_IGNORE = 2'd0,
    LK_EVENT  = 2'd1,
    LK_DATA   = 2'd2
  } line_kind_t;

  line_phase_t line_phase, line_phase_next;
  line_kind_t  line_kind, line_kind_next;
  logic [2:0]  name_position, name_position_next;
  logic        matches_event, matches_event_next;
  logic        matches_data, matches_data_next;
  logic        previous_was_cr, previous_was_cr_next;
  logic        seen_data, seen_data_next;
  logic [63:0] name_store, name_store_next;
  logic [3:0]  name_count, name_count_next;
  logic        name_overflow, name_overflow_next;
  logic [31:0] byte_total, byte_total_next;

  logic fire;
  logic do_field_char, do_field_colon, do_value, do_line_end, do_dispatch;
  logic emit_payload, emit_summary;
  logic [7:0] payload_sel;
  sse_pkg::queue_entry_t entry;

  function automatic logic event_char_ok(input logic [2:0] pos, input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    case (pos)
      3'd0: ok = (c == 8'h65);
      3'd1: ok = (c == 8'h76);
      3'd2: ok = (c == 8'h65);
      3'd3: ok = (c == 8'h6E);
      3'd4: ok = (c == 8'h74);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic data_char_ok(input logic [2:0] pos, input logic [7:0] c);
    logic ok;
    ok = 1'b0;
    case (pos)
      3'd0: ok = (c == 8'h64);
      3'd1: ok = (c == 8'h61);
      3'd2: ok = (c == 8'h74);
      3'd3: ok = (c == 8'h61);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  assign in_stall = q_status.full;
  assign fire     = in_valid && !in_stall;

  always_comb begin
    line_phase_next      = line_phase;
    line_kind_next       = line_kind;
    name_position_next   = name_position;
    matches_event_next   = matches_event;
    matches_data_next    = matches_data;
    previous_was_cr_next = previous_was_cr;
    seen_data_next       = seen_data;
    name_store_next      = name_store;
    name_count_next      = name_count;
    name_overflow_next   = name_overflow;
    byte_total_next      = byte_total;
    do_field_char  = 1'b0;
    do_field_colon = 1'b0;
    do_value       = 1'b0;
    do_line_end    = 1'b0;
    do_dispatch    = 1'b0;
    emit_payload   = 1'b0;
    emit_summary   = 1'b0;
    payload_sel    = '0;
    entry          = '0;

    // classify the item
    if (fire) begin
      unique case (operation)
        sse_pkg::OP_FEED: begin
          previous_was_cr_next = 1'b0;
          if (!(previous_was_cr && in_byte == sse_pkg::CH_LF)) begin
            if (in_byte == sse_pkg::CH_LF || in_byte == sse_pkg::CH_CR) begin
              if (line_phase == PH_START) begin
                do_dispatch = 1'b1;
              end else begin
                do_line_end = 1'b1;
              end
              previous_was_cr_next = (in_byte == sse_pkg::CH_CR);
            end else begin
              case (line_phase)
                PH_START: begin
                  if (in_byte == sse_pkg::CH_COLON) begin
                    line_kind_next  = LK_IGNORE;
                    line_phase_next = PH_VREST;
                  end else begin
                    line_phase_next = PH_NAME;
                    do_field_char   = 1'b1;
                  end
                end
                PH_NAME: begin
                  if (in_byte == sse_pkg::CH_COLON) begin
                    do_field_colon = 1'b1;
                  end else begin
                    do_field_char = 1'b1;
                  end
                end
                PH_VSTART: begin
                  line_phase_next = PH_VREST;
                  do_value        = (in_byte != sse_pkg::CH_SPACE);
                end
                default: begin
                  do_value = 1'b1;
                end
              endcase
            end
          end
        end
        sse_pkg::OP_FINISH: begin
          do_line_end = (line_phase != PH_START);
          do_dispatch = 1'b1;
        end
        sse_pkg::OP_RESET: begin
          line_phase_next      = PH_START;
          line_kind_next       = LK_IGNORE;
          name_position_next   = '0;
          matches_event_next   = 1'b1;
          matches_data_next    = 1'b1;
          previous_was_cr_next = 1'b0;
          seen_data_next       = 1'b0;
          name_store_next      = '0;
          name_count_next      = '0;
          name_overflow_next   = 1'b0;
          byte_total_next      = '0;
        end
        default: begin
        end
      endcase
    end

    // carry out the actions in the order the stream defines
    if (do_field_char) begin
      if (!event_char_ok(name_position, in_byte)) matches_event_next = 1'b0;
      if (!data_char_ok(name_position, in_byte)) matches_data_next = 1'b0;
      if (name_position != 3'd7) name_position_next = name_position + 3'd1;
    end

    if (do_field_colon) begin
      if (matches_event && name_position == 3'd5) begin
        line_kind_next     = LK_EVENT;
        name_store_next    = '0;
        name_count_next    = '0;
        name_overflow_next = 1'b0;
        line_phase_next    = PH_VSTART;
      end else if (matches_data && name_position == 3'd4) begin
        line_kind_next = LK_DATA;
        if (seen_data_next) begin
          emit_payload = 1'b1;
          payload_sel  = sse_pkg::CH_LF;
          if (byte_total_next != '1) byte_total_next = byte_total_next + 32'd1;
        end
        seen_data_next  = 1'b1;
        line_phase_next = PH_VSTART;
      end else begin
        line_kind_next  = LK_IGNORE;
        line_phase_next = PH_VREST;
      end
    end

    if (do_value) begin
      if (line_kind == LK_DATA) begin
        emit_payload = 1'b1;
        payload_sel  = in_byte;
        if (byte_total_next != '1) byte_total_next = byte_total_next + 32'd1;
      end else if (line_kind == LK_EVENT) begin
        if (name_count < 4'(sse_pkg::EVENT_NAME_BYTES)) begin
          name_store_next[8 * name_count[sse_pkg::NAME_IDX_W-1:0] +: 8] = in_byte;
          name_count_next = name_count + 4'd1;
        end else begin
          name_overflow_next = 1'b1;
        end
      end
    end

    if (do_line_end) begin
      if (line_phase == PH_NAME) begin
        if (matches_event && name_position == 3'd5) begin
          name_store_next    = '0;
          name_count_next    = '0;
          name_overflow_next = 1'b0;
        end else if (matches_data && name_position == 3'd4) begin
          if (seen_data_next) begin
            emit_payload = 1'b1;
            payload_sel  = sse_pkg::CH_LF;
            if (byte_total_next != '1) byte_total_next = byte_total_next + 32'd1;
          end
          seen_data_next = 1'b1;
        end
      end
      line_phase_next    = PH_START;
      name_position_next = '0;
      matches_event_next = 1'b1;
      matches_data_next  = 1'b1;
      line_kind_next     = LK_IGNORE;
    end

    if (do_dispatch) begin
      emit_summary            = seen_data_next;
      entry.data_length       = byte_total_next;
      entry.event_name        = name_store_next;
      entry.event_name_length = name_count_next;
      entry.name_truncated    = name_overflow_next;
      name_store_next    = '0;
      name_count_next    = '0;
      name_overflow_next = 1'b0;
      byte_total_next    = '0;
      seen_data_next     = 1'b0;
    end

    entry.has_payload  = emit_payload;
    entry.payload_byte = payload_sel;
    entry.has_summary  = emit_summary;
  end

  assign q_push  = fire && (emit_payload || emit_summary);
  assign q_entry = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase      <= PH_START;
      line_kind       <= LK_IGNORE;
      name_position   <= '0;
      matches_event   <= 1'b1;
      matches_data    <= 1'b1;
      previous_was_cr <= 1'b0;
      seen_data       <= 1'b0;
      name_store      <= '0;
      name_count      <= '0;
      name_overflow   <= 1'b0;
      byte_total      <= '0;
    end else begin
      line_phase      <= line_phase_next;
      line_kind       <= line_kind_next;
      name_position   <= name_position_next;
      matches_event   <= matches_event_next;
      matches_data    <= matches_data_next;
      previous_was_cr <= previous_was_cr_next;
      seen_data       <= seen_data_next;
      name_store      <= name_store_next;
      name_count      <= name_count_next;
      name_overflow   <= name_overflow_next;
      byte_total      <= byte_total_next;
    end
  end

`ifndef SYNTHESIS
  a_name_count_bound: assert property (@(posedge clk) disable iff (rst)
    name_count <= 4'(sse_pkg::EVENT_NAME_BYTES))
    else $error("event name count beyond storage");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    name_overflow |-> name_count == 4'(sse_pkg::EVENT_NAME_BYTES))
    else $error("name overflow flagged with storage not full");
`endif

endmodule

// ===== hdl/sse_fifo.sv =====
module sse_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sse_pkg::queue_entry_t  push_data,
  input  logic                   pop,
  output sse_pkg::queue_entry_t  pop_data,
  output sse_pkg::queue_status_t status
);

  sse_pkg::queue_entry_t entries [sse_pkg::QUEUE_DEPTH];
  logic [sse_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [sse_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [sse_pkg::QUEUE_CW-1:0] count;

  assign pop_data     = entries[rd_ptr];
  assign status.full  = (count == sse_pkg::QUEUE_CW'(sse_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + sse_pkg::QUEUE_AW'(1);
      if (pop) rd_ptr <= rd_ptr + sse_pkg::QUEUE_AW'(1);
      if (push && !pop) begin
        count <= count + sse_pkg::QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - sse_pkg::QUEUE_CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue read while empty");
`endif

endmodule

// ===== hdl/sse_back.sv =====
module sse_back (
  input  logic                   clk,
  input  logic                   rst,
  input  sse_pkg::queue_entry_t  q_entry,
  input  sse_pkg::queue_status_t q_status,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   kind,
  output logic [7:0]             payload_byte,
  output logic [31:0]            data_length,
  output logic [63:0]            event_name,
  output logic [3:0]             event_name_length,
  output logic                   name_truncated,
  output logic                   last
);

  logic load;
  logic take_payload;
  logic second;

  assign load         = !out_valid || !out_stall;
  assign take_payload = q_entry.has_payload && !second;

  always_comb begin
    q_pop = 1'b0;
    if (load && !q_status.empty) begin
      q_pop = take_payload ? !q_entry.has_summary : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else if (load) begin
      if (!q_status.empty) begin
        out_valid <= 1'b1;
        if (take_payload) begin
          kind              <= sse_pkg::KIND_DATA;
          payload_byte      <= q_entry.payload_byte;
          data_length       <= '0;
          event_name        <= '0;
          event_name_length <= '0;
          name_truncated    <= 1'b0;
          last              <= !q_entry.has_summary;
          second            <= q_entry.has_summary;
        end else begin
          kind              <= sse_pkg::KIND_EVENT;
          payload_byte      <= '0;
          data_length       <= q_entry.data_length;
          event_name        <= q_entry.event_name;
          event_name_length <= q_entry.event_name_length;
          name_truncated    <= q_entry.name_truncated;
          last              <= 1'b1;
          second            <= 1'b0;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_second_has_summary: assert property (@(posedge clk) disable iff (rst)
    second |-> (!q_status.empty && q_entry.has_summary))
    else $error("summary pending without a queued summary");
`endif

endmodule

// ===== hdl/sse_event_stream_parser.sv =====
// A result is registered on its way out: the queue write at its item transfer edge,
// then the output register, which holds it while out_stall is high.
// Throughput: one item per cycle unless in_stall (queue full); a finish that yields
// a data newline and a summary gives two transfers; the 4-entry queue absorbs it.
// Reset (rst, synchronous): parser returns to line start with empty name and zero
// length, the queue empties and any result not yet transferred is dropped.
module sse_event_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [31:0] data_length,
  output logic [63:0] event_name,
  output logic [3:0]  event_name_length,
  output logic        name_truncated,
  output logic        last
);

  // Front to queue
  logic                   q_push;
  sse_pkg::queue_entry_t  q_in;
  // Queue to back
  logic                   q_pop;
  sse_pkg::queue_entry_t  q_head;
  sse_pkg::queue_status_t q_status;

  // Front: take a transfer, advance the line parser, record its results
  sse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .in_byte   (in_byte),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  // Queue: hold result records so each side can stall on its own
  sse_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_head),
    .status    (q_status)
  );

  // Back: expand each record into one or two result transfers
  sse_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_entry           (q_head),
    .q_status          (q_status),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .kind              (kind),
    .payload_byte      (payload_byte),
    .data_length       (data_length),
    .event_name        (event_name),
    .event_name_length (event_name_length),
    .name_truncated    (name_truncated),
    .last              (last)
  );

endmodule
